FILE: design/leq_pkg.sv
// ----------------------------------------------------------------------------
// leq_pkg
// Shared types and constants for the line editor with history recall.
// ----------------------------------------------------------------------------
package leq_pkg;

  localparam int unsigned LEQ_MAX_LINE = 254;

  localparam logic [7:0] LEQ_LIMIT_RESET = 8'd100;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_TILDE = 8'd126;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] EV_ABSORB = 2'd0;
  localparam logic [1:0] EV_LINE   = 2'd1;
  localparam logic [1:0] EV_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_WALK_LAST
  } leq_state_t;

endpackage

FILE: design/leq_ram.sv
// ----------------------------------------------------------------------------
// leq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module leq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 254
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/line_editor_with_history_recall_unit.sv
// ----------------------------------------------------------------------------
// line_editor_with_history_recall_unit
// Edits received bytes into command lines, keeps the previous line for
// '!' recall, counts repeated lines and reads the finished command back.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | opcode, data_byte, read_index
//  out      | out_valid / out_stall| event_res, line_length, from_history,
//           |                      | truncated, repeat_warning, read_byte
//  cfg      | cfg_we               | cfg_wdata (repeat_limit)
//
//  A received byte that does not end a line, a replay and an empty line are
//  finished in ST_IDLE; a read goes through ST_READ for the history RAM read.
//  A stored line goes through ST_WALK and ST_WALK_LAST: one shared compare
//  unit walks the edit and history RAMs one entry a cycle, copying into history.
//  Synchronous reset clears lengths, counter and flags; RAM contents are not
//  cleared. in_stall is high while an item is at work or a result is held.
// ----------------------------------------------------------------------------
module line_editor_with_history_recall_unit #(
  parameter int unsigned MAX_LINE = leq_pkg::LEQ_MAX_LINE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] data_byte,
  input  logic [7:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] event_res,
  output logic [7:0] line_length,
  output logic       from_history,
  output logic       truncated,
  output logic       repeat_warning,
  output logic [7:0] read_byte
);

  import leq_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LINE);
  localparam int unsigned LW = $clog2(MAX_LINE + 1);
  localparam int unsigned XW = (LW > 8) ? LW : 8;

  function automatic logic [7:0] low_byte(input logic [LW-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v);
    return e[7:0];
  endfunction

  leq_state_t state, state_next;

  logic [7:0]    repeat_limit;
  logic [LW-1:0] edit_length, edit_length_next;
  logic [LW-1:0] history_length, history_length_next;
  logic [7:0]    repeat_count, repeat_count_next;
  logic          after_line_end, after_line_end_next;
  logic          discarding, discarding_next;
  logic [7:0]    first_char, first_char_next;
  logic [LW-1:0] cnt, cnt_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] wr_addr, wr_addr_next;
  logic          same, same_next;
  logic          cut, cut_next;
  logic          read_hit, read_hit_next;
  logic          out_valid_next;
  logic [1:0]    event_res_next;
  logic [7:0]    line_length_next;
  logic          from_history_next;
  logic          truncated_next;
  logic          repeat_warning_next;
  logic [7:0]    read_byte_next;

  logic          eram_we;
  logic [AW-1:0] eram_waddr;
  logic [AW-1:0] eram_raddr;
  logic [7:0]    eram_rdata;
  logic          hram_we;
  logic [AW-1:0] hram_waddr;
  logic [7:0]    hram_wdata;
  logic [AW-1:0] hram_raddr;
  logic [7:0]    hram_rdata;

  logic          accept;
  logic          is_term;
  logic          is_print;
  logic          is_full;
  logic          finish_req;
  logic          walk_start;
  logic [XW-1:0] idx_ext;
  logic          idx_hit;
  logic [7:0]    count_inc;
  logic          same_all;

  assign in_stall   = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign is_term    = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign is_print   = (data_byte >= CH_SPACE) && (data_byte <= CH_TILDE);
  assign is_full    = (edit_length == LW'(MAX_LINE));
  assign finish_req = !discarding && ((is_term && !after_line_end) || (!is_term && is_full));
  assign walk_start = accept && (opcode == OP_RECV) && finish_req
                      && (edit_length != '0) && (first_char != CH_BANG);
  assign idx_ext    = XW'(read_index);
  assign idx_hit    = idx_ext < XW'(history_length);
  assign count_inc  = (repeat_count == 8'hFF) ? 8'hFF : repeat_count + 8'd1;
  assign same_all   = same && (eram_rdata == hram_rdata);
  assign eram_raddr = cnt[AW-1:0];

  leq_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_edit_ram (
    .clk   (clk),
    .we    (eram_we),
    .waddr (eram_waddr),
    .wdata (data_byte),
    .raddr (eram_raddr),
    .rdata (eram_rdata)
  );

  leq_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_hist_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (hram_waddr),
    .wdata (hram_wdata),
    .raddr (hram_raddr),
    .rdata (hram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_READ)) begin
          state_next = ST_READ;
        end else if (walk_start) begin
          state_next = ST_WALK;
        end
      end
      ST_READ:      state_next = ST_IDLE;
      ST_WALK: begin
        if (cnt == edit_length - LW'(1)) begin
          state_next = ST_WALK_LAST;
        end
      end
      ST_WALK_LAST: state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    edit_length_next    = edit_length;
    history_length_next = history_length;
    repeat_count_next   = repeat_count;
    after_line_end_next = after_line_end;
    discarding_next     = discarding;
    first_char_next     = first_char;
    cnt_next            = cnt;
    rd_vld_next         = 1'b0;
    wr_addr_next        = wr_addr;
    same_next           = same;
    cut_next            = cut;
    read_hit_next       = read_hit;
    out_valid_next      = out_valid && out_stall;
    event_res_next      = event_res;
    line_length_next    = line_length;
    from_history_next   = from_history;
    truncated_next      = truncated;
    repeat_warning_next = repeat_warning;
    read_byte_next      = read_byte;
    eram_we             = 1'b0;
    eram_waddr          = edit_length[AW-1:0];
    hram_we             = 1'b0;
    hram_waddr          = wr_addr;
    hram_wdata          = eram_rdata;
    hram_raddr          = cnt[AW-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          event_res_next      = EV_ABSORB;
          line_length_next    = 8'd0;
          from_history_next   = 1'b0;
          truncated_next      = 1'b0;
          repeat_warning_next = 1'b0;
          read_byte_next      = 8'd0;
          if (opcode == OP_READ) begin
            hram_raddr    = idx_ext[AW-1:0];
            read_hit_next = idx_hit;
          end else begin
            out_valid_next = !walk_start;
            if (is_term) begin
              after_line_end_next = 1'b1;
              if (discarding) begin
                discarding_next = 1'b0;
              end
            end else begin
              after_line_end_next = 1'b0;
              if (!discarding && is_full) begin
                discarding_next = 1'b1;
              end else if (!discarding && (data_byte == CH_BS)) begin
                if (edit_length != '0) begin
                  edit_length_next = edit_length - LW'(1);
                end
              end else if (!discarding && is_print) begin
                eram_we          = 1'b1;
                edit_length_next = edit_length + LW'(1);
                if (edit_length == '0) begin
                  first_char_next = data_byte;
                end
              end
            end
            if (finish_req) begin
              cut_next       = !is_term;
              truncated_next = !is_term;
              event_res_next = EV_LINE;
              if (edit_length == '0) begin
                hram_we             = 1'b1;
                hram_waddr          = '0;
                hram_wdata          = CH_SPACE;
                history_length_next = LW'(1);
                line_length_next    = 8'd1;
              end else if (first_char == CH_BANG) begin
                edit_length_next    = '0;
                repeat_count_next   = count_inc;
                repeat_warning_next = count_inc >= repeat_limit;
                from_history_next   = 1'b1;
                line_length_next    = low_byte(history_length);
              end else begin
                cnt_next  = '0;
                same_next = (edit_length == history_length);
              end
            end
          end
        end
      end
      ST_READ: begin
        out_valid_next      = 1'b1;
        event_res_next      = EV_READ;
        line_length_next    = low_byte(history_length);
        from_history_next   = 1'b0;
        truncated_next      = 1'b0;
        repeat_warning_next = 1'b0;
        read_byte_next      = read_hit ? hram_rdata : 8'd0;
      end
      ST_WALK: begin
        cnt_next     = cnt + LW'(1);
        rd_vld_next  = 1'b1;
        wr_addr_next = cnt[AW-1:0];
        if (rd_vld) begin
          hram_we   = 1'b1;
          same_next = same_all;
        end
      end
      ST_WALK_LAST: begin
        hram_we             = 1'b1;
        history_length_next = edit_length;
        edit_length_next    = '0;
        out_valid_next      = 1'b1;
        event_res_next      = EV_LINE;
        line_length_next    = low_byte(edit_length);
        from_history_next   = 1'b0;
        truncated_next      = cut;
        repeat_warning_next = 1'b0;
        read_byte_next      = 8'd0;
        if (edit_length > LW'(1)) begin
          if (same_all) begin
            repeat_count_next   = count_inc;
            repeat_warning_next = count_inc >= repeat_limit;
          end else begin
            repeat_count_next = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      repeat_limit   <= LEQ_LIMIT_RESET;
      edit_length    <= '0;
      history_length <= '0;
      repeat_count   <= 8'd0;
      after_line_end <= 1'b0;
      discarding     <= 1'b0;
      rd_vld         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      if (cfg_we) begin
        repeat_limit <= cfg_wdata;
      end
      edit_length    <= edit_length_next;
      history_length <= history_length_next;
      repeat_count   <= repeat_count_next;
      after_line_end <= after_line_end_next;
      discarding     <= discarding_next;
      rd_vld         <= rd_vld_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    first_char     <= first_char_next;
    cnt            <= cnt_next;
    wr_addr        <= wr_addr_next;
    same           <= same_next;
    cut            <= cut_next;
    read_hit       <= read_hit_next;
    event_res      <= event_res_next;
    line_length    <= line_length_next;
    from_history   <= from_history_next;
    truncated      <= truncated_next;
    repeat_warning <= repeat_warning_next;
    read_byte      <= read_byte_next;
  end

  a_edit_len_bound: assert property (@(posedge clk) disable iff (rst)
    edit_length <= LW'(MAX_LINE))
    else $error("edit length beyond line limit");

  a_hist_len_bound: assert property (@(posedge clk) disable iff (rst)
    history_length <= LW'(MAX_LINE))
    else $error("history length beyond line limit");

  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    (discarding && (state == ST_IDLE)) |-> (edit_length == '0))
    else $error("edit line not empty while discarding");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_LAST) |=> (edit_length == '0 && out_valid && event_res == EV_LINE))
    else $error("line end walk did not finish the line");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: line editor with history recall
// Drives received bytes and read-backs through the valid/stall channels,
// predicts each result with a cycle-free model of the line discipline and
// checks every output field in order. A directed script covers the empty
// line, replay with no previous line, backspace, dropped bytes and an
// overlong line. Random phases follow under several repeat_limit settings;
// all but the last add random sending-side gaps and random result-side stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import leq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned PHASE_ITEMS = 12;
  localparam int unsigned BANG_BURST  = 258;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] line_length;
    logic       from_history;
    logic       truncated;
    logic       repeat_warning;
    logic [7:0] read_byte;
  } line_result_t;

  typedef struct {
    logic         op;
    logic [7:0]   data;
    logic [7:0]   idx;
    int           reps;
    bit           typed;
    line_result_t want;
  } stim_row_t;

  localparam line_result_t ABSORBED = '0;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       opcode = OP_RECV;
  logic [7:0] data_byte = 8'd0;
  logic [7:0] read_index = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] event_res;
  logic [7:0] line_length;
  logic       from_history;
  logic       truncated;
  logic       repeat_warning;
  logic [7:0] read_byte;

  line_editor_with_history_recall_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .read_index    (read_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .line_length   (line_length),
    .from_history  (from_history),
    .truncated     (truncated),
    .repeat_warning(repeat_warning),
    .read_byte     (read_byte)
  );

  // editor state mirror
  logic [7:0]  edit_buf [LEQ_MAX_LINE];
  logic [7:0]  hist_buf [LEQ_MAX_LINE];
  int unsigned edit_len = 0;
  int unsigned hist_len = 0;
  int unsigned rep_count = 0;
  bit          line_ended = 1'b0;
  bit          skipping = 1'b0;
  logic [7:0]  limit = LEQ_LIMIT_RESET;

  line_result_t editor_results_due [$];
  stim_row_t    script [$];

  bit          idling = 1'b1;
  int          stall_left = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned mismatches = 0;
  int unsigned n_lines = 0, n_cut = 0, n_replay = 0, n_warn = 0, n_reads = 0;
  int unsigned n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || !idling) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic line_result_t close_line(bit cut);
    line_result_t r;
    int unsigned  k;
    int unsigned  i;
    bit           bang;
    bit           same;
    bit           warn;
    r = '0;
    k = edit_len;
    warn = 1'b0;
    if (k == 0) begin
      edit_buf[0] = CH_SPACE;
      k = 1;
    end
    bang = (edit_buf[0] == CH_BANG);
    if (k > 1 || bang) begin
      same = (k == hist_len);
      for (i = 0; i < k && same; i++) begin
        if (edit_buf[i] != hist_buf[i]) same = 1'b0;
      end
      if (!bang && !same) begin
        rep_count = 0;
      end else begin
        if (rep_count < 255) rep_count++;
        warn = (rep_count >= limit);
      end
    end
    if (!bang) begin
      for (i = 0; i < k; i++) hist_buf[i] = edit_buf[i];
      hist_len = k;
    end
    edit_len = 0;
    r.event_res      = EV_LINE;
    r.line_length    = 8'(hist_len);
    r.from_history   = bang;
    r.truncated      = cut;
    r.repeat_warning = warn;
    return r;
  endfunction

  function automatic line_result_t next_editor_result(logic op, logic [7:0] b,
                                                      logic [7:0] idx);
    line_result_t r;
    r = '0;
    if (op == OP_READ) begin
      r.event_res   = EV_READ;
      r.line_length = 8'(hist_len);
      if (idx < hist_len) r.read_byte = hist_buf[idx];
      return r;
    end
    if (b == CH_CR || b == CH_LF) begin
      if (skipping) begin
        skipping   = 1'b0;
        line_ended = 1'b1;
      end else if (!line_ended) begin
        r = close_line(1'b0);
        line_ended = 1'b1;
      end
      return r;
    end
    line_ended = 1'b0;
    if (skipping) return r;
    if (edit_len >= LEQ_MAX_LINE) begin
      r = close_line(1'b1);
      skipping = 1'b1;
      return r;
    end
    if (b == CH_BS) begin
      if (edit_len > 0) edit_len--;
    end else if (b >= CH_SPACE && b <= CH_TILDE) begin
      edit_buf[edit_len] = b;
      edit_len++;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (editor_results_due.size() == 0) begin
        $error("result with no expectation waiting: event_res %0d", event_res);
        mismatches++;
      end else begin
        want = editor_results_due.pop_front();
        check_field("event_res", 8'(want.event_res), 8'(event_res));
        check_field("line_length", want.line_length, line_length);
        check_field("from_history", 8'(want.from_history), 8'(from_history));
        check_field("truncated", 8'(want.truncated), 8'(truncated));
        check_field("repeat_warning", 8'(want.repeat_warning), 8'(repeat_warning));
        check_field("read_byte", want.read_byte, read_byte);
        if (want.event_res == EV_LINE) n_lines++;
        if (want.event_res == EV_READ) n_reads++;
        if (want.truncated) n_cut++;
        if (want.from_history) n_replay++;
        if (want.repeat_warning) n_warn++;
      end
    end
  end

  task automatic transfer(logic op, logic [7:0] b, logic [7:0] idx, bit typed,
                          line_result_t want);
    line_result_t predicted;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    predicted = next_editor_result(op, b, idx);
    editor_results_due.push_back(typed ? want : predicted);
    in_valid   <= 1'b1;
    opcode     <= op;
    data_byte  <= b;
    read_index <= idx;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    transfer(OP_RECV, b, 8'($urandom_range(0, 253)), 1'b0, ABSORBED);
  endtask

  task automatic read_back(logic [7:0] idx);
    transfer(OP_READ, 8'($urandom_range(0, 255)), idx, 1'b0, ABSORBED);
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (editor_results_due.size() != 0);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit = v;
    n_settings++;
  endtask

  task automatic add_row(logic op, logic [7:0] data, logic [7:0] idx, int reps,
                         bit typed, line_result_t want);
    stim_row_t row;
    row.op    = op;
    row.data  = data;
    row.idx   = idx;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_SPACE, CH_TILDE));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while ((v >= CH_SPACE && v <= CH_TILDE) || v == CH_CR || v == CH_LF || v == CH_BS)
      v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 253));
    return 8'($urandom_range(0, (hist_len + 1 > 253) ? 253 : hist_len + 1));
  endfunction

  task automatic send_end();
    case ($urandom_range(0, 4))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      2: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      3: begin
        send_byte(CH_LF);
        send_byte(CH_CR);
      end
      default: begin
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  task automatic send_line();
    int         kind;
    int         n;
    int         i;
    logic [7:0] copy [$];
    kind = $urandom_range(0, 99);
    if (kind >= 40 && kind < 65 && hist_len > 0) begin
      for (i = 0; i < hist_len; i++) copy.push_back(hist_buf[i]);
      foreach (copy[j]) send_byte(copy[j]);
      send_end();
    end else if (kind >= 65 && kind < 80) begin
      send_byte(CH_BANG);
      repeat ($urandom_range(0, 4)) send_byte(printable());
      send_end();
    end else if (kind >= 80 && kind < 90) begin
      send_byte(noise_byte());
      send_end();
    end else if (kind >= 90) begin
      repeat ($urandom_range(1, 3)) read_back(pick_index());
    end else if ($urandom_range(0, 24) == 0) begin
      repeat ($urandom_range(252, 257)) send_byte(printable());
      send_end();
    end else begin
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 19))
          0: send_byte(noise_byte());
          1: send_byte(CH_BS);
          2: read_back(pick_index());
          default: send_byte(printable());
        endcase
      end
      send_end();
    end
  endtask

  initial begin
    int unsigned phase_end;
    int          ph;
    logic [7:0]  lim;

    add_row(OP_READ, 8'd0, 8'd0, 1, 1'b1, line_result_t'{EV_READ, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0});
    add_row(OP_RECV, CH_BANG, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b1, line_result_t'{EV_LINE, 8'd0, 1'b1, 1'b0, 1'b0, 8'd0});
    add_row(OP_RECV, CH_LF, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, 8'h00, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b1, line_result_t'{EV_LINE, 8'd1, 1'b0, 1'b0, 1'b0, 8'd0});
    add_row(OP_READ, 8'hFF, 8'd0, 1, 1'b1, line_result_t'{EV_READ, 8'd1, 1'b0, 1'b0, 1'b0, CH_SPACE});
    add_row(OP_RECV, 8'hFF, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_BS, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_SPACE, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_TILDE, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_BS, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, 8'h7F, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, "x", 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b1, line_result_t'{EV_LINE, 8'd2, 1'b0, 1'b0, 1'b0, 8'd0});
    add_row(OP_RECV, CH_BANG, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_LF, 8'd0, 1, 1'b1, line_result_t'{EV_LINE, 8'd2, 1'b1, 1'b0, 1'b0, 8'd0});
    add_row(OP_READ, 8'd0, 8'd1, 1, 1'b1, line_result_t'{EV_READ, 8'd2, 1'b0, 1'b0, 1'b0, "x"});
    add_row(OP_READ, 8'd0, 8'd253, 1, 1'b1, line_result_t'{EV_READ, 8'd2, 1'b0, 1'b0, 1'b0, 8'd0});
    add_row(OP_RECV, CH_SPACE, 8'd0, 1, 1'b0, ABSORBED);
    add_row(OP_RECV, "x", 8'd0, 1, 1'b0, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b0, ABSORBED);
    add_row(OP_RECV, "a", 8'd0, LEQ_MAX_LINE, 1'b1, ABSORBED);
    add_row(OP_RECV, "b", 8'd0, 1, 1'b1, line_result_t'{EV_LINE, 8'd254, 1'b0, 1'b1, 1'b0, 8'd0});
    add_row(OP_RECV, "c", 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_CR, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_RECV, CH_LF, 8'd0, 1, 1'b1, ABSORBED);
    add_row(OP_READ, 8'd0, 8'd253, 1, 1'b1, line_result_t'{EV_READ, 8'd254, 1'b0, 1'b0, 1'b0, "a"});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      repeat (script[r].reps)
        transfer(script[r].op, script[r].data, script[r].idx, script[r].typed, script[r].want);
    end

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: lim = 8'd1;
        1: lim = 8'd255;
        2: lim = 8'd3;
        default: lim = 8'($urandom_range(1, 255));
      endcase
      idling = (ph < 4);
      write_limit(lim);
      // saturate the repeat counter with replays
      if (ph == 1) begin
        repeat (BANG_BURST) begin
          send_byte(CH_BANG);
          send_byte(CH_CR);
        end
      end
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        send_line();
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d transfers: %0d lines, %0d cut off, %0d replays, %0d warnings",
             sent, n_lines, n_cut, n_replay, n_warn);
    $display("  plus %0d read-backs under %0d repeat_limit settings", n_reads, n_settings);
    if (mismatches == 0 && editor_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
